/* hw/rtl/pump_proportional_duty_ctrl_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pump duty controller
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PUMP_PROPORTIONAL_DUTY_CTRL_MACROS_SVH
`define PUMP_PROPORTIONAL_DUTY_CTRL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PPDC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ppdc: same-cycle check failed");
// Next-cycle implication.
`define PPDC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ppdc: next-cycle check failed");
`else
`define PPDC_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define PPDC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

/* hw/rtl/ppdc_pkg.sv */
// ----------------------------------------------------------------------------
// ppdc_pkg
// Types, register indexes, status codes and reset values of the pump
// proportional duty controller.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  localparam int PWM_BITS_DEF = 10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_PRESSURE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_FLOOR      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DUTY_CEILING    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_STEP       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERVAC_LIMIT   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEAK_TIMEOUT    = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_OVERVAC = 2'd1;
  localparam logic [1:0] ST_LEAK    = 2'd2;

  // Full scale duty, tenths of percent
  localparam logic [9:0] DUTY_FULL = 10'd1000;

  // Register reset values
  localparam logic signed [13:0] TARGET_PRESSURE_RST = -14'sd1000;
  localparam logic [11:0]        PROP_GAIN_RST       = 12'd512;
  localparam logic [9:0]         DUTY_FLOOR_RST      = 10'd300;
  localparam logic [9:0]         DUTY_CEILING_RST    = 10'd1000;
  localparam logic [9:0]         SLEW_STEP_RST       = 10'd50;
  localparam logic signed [14:0] OVERVAC_LIMIT_RST   = -15'sd2000;
  localparam logic [31:0]        LEAK_TIMEOUT_RST    = 32'd60000;

  typedef struct packed {
    logic               running;
    logic signed [15:0] pressure;
    logic [31:0]        now_ms;
  } ppdc_in_t;

  typedef struct packed {
    logic [9:0] duty_tenths;
    logic [9:0] pwm_compare;
    logic       pump_on;
    logic [1:0] status;
  } ppdc_out_t;

  // Result of the duty stage, before the compare value is scaled
  typedef struct packed {
    logic [9:0] duty_tenths;
    logic       pump_on;
    logic [1:0] status;
  } ppdc_mid_t;

  typedef struct packed {
    logic signed [13:0] target_pressure;
    logic [11:0]        prop_gain;
    logic [9:0]         duty_floor;
    logic [9:0]         duty_ceiling;
    logic [9:0]         slew_step;
    logic signed [14:0] overvac_limit;
    logic [31:0]        leak_timeout;
  } ppdc_cfg_t;

endpackage

/* hw/rtl/ppdc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ppdc_cfg_regs
// Configuration register file; writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module ppdc_cfg_regs
  import ppdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output ppdc_cfg_t             cfg
);

  ppdc_cfg_t cfg_r;
  ppdc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_TARGET_PRESSURE: cfg_nxt.target_pressure = $signed(cfg_wdata[13:0]);
        CFG_PROP_GAIN:       cfg_nxt.prop_gain       = cfg_wdata[11:0];
        CFG_DUTY_FLOOR:      cfg_nxt.duty_floor      = cfg_wdata[9:0];
        CFG_DUTY_CEILING:    cfg_nxt.duty_ceiling    = cfg_wdata[9:0];
        CFG_SLEW_STEP:       cfg_nxt.slew_step       = cfg_wdata[9:0];
        CFG_OVERVAC_LIMIT:   cfg_nxt.overvac_limit   = $signed(cfg_wdata[14:0]);
        CFG_LEAK_TIMEOUT:    cfg_nxt.leak_timeout    = cfg_wdata[31:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_pressure <= TARGET_PRESSURE_RST;
      cfg_r.prop_gain       <= PROP_GAIN_RST;
      cfg_r.duty_floor      <= DUTY_FLOOR_RST;
      cfg_r.duty_ceiling    <= DUTY_CEILING_RST;
      cfg_r.slew_step       <= SLEW_STEP_RST;
      cfg_r.overvac_limit   <= OVERVAC_LIMIT_RST;
      cfg_r.leak_timeout    <= LEAK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/ppdc_duty_core.sv */
// ----------------------------------------------------------------------------
// ppdc_duty_core
// Duty computation for one update and the controller state it updates:
// proportional target, slew limit, over-vacuum and leak stops.
// ----------------------------------------------------------------------------
`include "pump_proportional_duty_ctrl_macros.svh"

module ppdc_duty_core
  import ppdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ppdc_cfg_t cfg,
  input  ppdc_in_t  item,
  input  logic      step,
  output ppdc_mid_t res
);

  logic [9:0]  cur_duty_r, cur_duty_nxt;
  logic        reached_r, reached_nxt;
  logic        started_r, started_nxt;
  logic [31:0] start_r, start_nxt;

  logic signed [16:0] err;
  logic               err_pos;
  logic [27:0]        prod;
  logic [19:0]        want_raw;
  logic [9:0]         want_c;
  logic [9:0]         want;
  logic [10:0]        up;
  logic signed [11:0] dn;
  logic signed [11:0] slewed;
  logic [9:0]         applied;
  logic               overvac;
  logic               reach_hit;
  logic [31:0]        start_eff;
  logic [31:0]        elapsed;
  logic               leak;
  logic [9:0]         duty_out;
  logic [1:0]         status;

  assign err     = 17'(item.pressure) - 17'(cfg.target_pressure);
  assign err_pos = !err[16] && (err != 17'sd0);
  assign prod    = 28'(cfg.prop_gain) * 28'(err[15:0]);
  assign want_raw = prod[27:8];

  // Clamp to the ceiling first, then raise to the floor, so the floor wins.
  assign want_c = (want_raw > 20'(cfg.duty_ceiling)) ? cfg.duty_ceiling : want_raw[9:0];
  always_comb begin
    if (!err_pos) begin
      want = cfg.duty_floor;
    end else if (want_c < cfg.duty_floor) begin
      want = cfg.duty_floor;
    end else begin
      want = want_c;
    end
  end

  assign up = 11'(cur_duty_r) + 11'(cfg.slew_step);
  assign dn = $signed(12'(cur_duty_r)) - $signed(12'(cfg.slew_step));

  always_comb begin
    if (11'(want) > up) begin
      slewed = $signed(12'(up));
    end else if ($signed(12'(want)) < dn) begin
      slewed = dn;
    end else begin
      slewed = $signed(12'(want));
    end
  end

  // Here the ceiling wins over the floor.
  always_comb begin
    if (slewed < 12'sd0) begin
      applied = '0;
    end else if (slewed[10:0] > 11'(cfg.duty_ceiling)) begin
      applied = cfg.duty_ceiling;
    end else begin
      applied = slewed[9:0];
    end
  end

  assign overvac   = item.pressure < 16'(cfg.overvac_limit);
  assign reach_hit = item.pressure <= 16'(cfg.target_pressure);
  assign start_eff = started_r ? start_r : item.now_ms;
  assign elapsed   = item.now_ms - start_eff;
  assign leak      = !(reached_r || reach_hit) && (elapsed > cfg.leak_timeout);

  always_comb begin
    cur_duty_nxt = cur_duty_r;
    reached_nxt  = reached_r;
    started_nxt  = started_r;
    start_nxt    = start_r;
    status       = ST_NORMAL;
    if (!item.running) begin
      cur_duty_nxt = '0;
      started_nxt  = 1'b0;
    end else if (overvac) begin
      cur_duty_nxt = '0;
      reached_nxt  = 1'b0;
      started_nxt  = 1'b0;
      status       = ST_OVERVAC;
    end else if (leak) begin
      cur_duty_nxt = '0;
      reached_nxt  = 1'b0;
      started_nxt  = 1'b0;
      start_nxt    = start_eff;
      status       = ST_LEAK;
    end else begin
      cur_duty_nxt = applied;
      reached_nxt  = reached_r || reach_hit;
      started_nxt  = 1'b1;
      start_nxt    = start_eff;
    end
  end

  assign duty_out        = cur_duty_nxt;
  assign res.duty_tenths = duty_out;
  assign res.pump_on     = duty_out >= cfg.duty_floor;
  assign res.status      = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_duty_r <= '0;
      reached_r  <= 1'b0;
      started_r  <= 1'b0;
      start_r    <= '0;
    end else if (step) begin
      cur_duty_r <= cur_duty_nxt;
      reached_r  <= reached_nxt;
      started_r  <= started_nxt;
      start_r    <= start_nxt;
    end
  end

  `PPDC_ASSERT_NEXT(a_idle_zero_duty, clk, rst_n, step && !item.running, cur_duty_r == '0)
  `PPDC_ASSERT_NEXT(a_stop_clears, clk, rst_n, step && (status != ST_NORMAL),
                    !started_r && !reached_r && (cur_duty_r == '0))
  `PPDC_ASSERT_NEXT(a_run_starts_timer, clk, rst_n,
                    step && item.running && (status == ST_NORMAL), started_r)

endmodule

/* hw/rtl/ppdc_pwm_scale.sv */
// ----------------------------------------------------------------------------
// ppdc_pwm_scale
// Inverted compare value (1000 - duty) * (2^PWM_BITS - 1) / 1000, truncated,
// kept to 10 bits. The divide is a reciprocal multiply, exact for this range.
// ----------------------------------------------------------------------------
module ppdc_pwm_scale
  import ppdc_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic [9:0] duty,
  output logic [9:0] pwm_compare
);

  localparam int XW         = PWM_BITS + 10;
  localparam int RecipShift = PWM_BITS + 20;
  localparam int MW         = PWM_BITS + 11;
  localparam int ProdW      = (2 * PWM_BITS + 21 > RecipShift + 10) ?
                              2 * PWM_BITS + 21 : RecipShift + 10;
  localparam longint unsigned RecipL =
    ((64'd1 << RecipShift) + 64'd999) / 64'd1000;
  localparam logic [MW-1:0] Recip = MW'(RecipL);

  logic [9:0]       inv;
  logic [XW-1:0]    scaled;
  logic [ProdW-1:0] prod;

  assign inv    = (duty >= DUTY_FULL) ? 10'd0 : DUTY_FULL - duty;
  // inv * (2^PWM_BITS - 1) as a shift and subtract
  assign scaled = {inv, {PWM_BITS{1'b0}}} - XW'(inv);
  assign prod   = ProdW'(scaled) * ProdW'(Recip);
  assign pwm_compare = prod[RecipShift +: 10];

endmodule

/* hw/rtl/pump_proportional_duty_ctrl.sv */
// ----------------------------------------------------------------------------
// pump_proportional_duty_ctrl: throughput one update per cycle while the
// output is not stalled; stages are input, gain multiply and duty with
// state update, then the compare-value reciprocal multiply.
// Synchronous active-low reset restores register defaults and clears state.
// ----------------------------------------------------------------------------
`include "pump_proportional_duty_ctrl_macros.svh"

module pump_proportional_duty_ctrl
  import ppdc_pkg::*;
#(
  parameter int PWM_BITS = PWM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ppdc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ppdc_out_t             out_data
);

  localparam logic [9:0] PwmAtZero = 10'(((64'd1 << PWM_BITS) - 64'd1) & 64'h3FF);

  ppdc_cfg_t cfg;
  ppdc_mid_t mid;
  logic [9:0] pwm_compare;

  logic      s1_v_r, s1_v_nxt;
  logic      s2_v_r, s2_v_nxt;
  logic      s3_v_r, s3_v_nxt;
  ppdc_in_t  s1_r;
  ppdc_mid_t s2_r;
  ppdc_out_t s3_r;

  logic s3_free, s2_free, s1_free;
  logic s1_adv, s2_adv, in_xfer;

  ppdc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  ppdc_duty_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .cfg  (cfg),
    .item (s1_r),
    .step (s1_adv),
    .res  (mid)
  );

  ppdc_pwm_scale #(
    .PWM_BITS(PWM_BITS)
  ) u_pwm (
    .duty       (s2_r.duty_tenths),
    .pwm_compare(pwm_compare)
  );

  // A stage takes new data when it is empty or its content moves on.
  assign s3_free = !s3_v_r || !out_stall;
  assign s2_adv  = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_adv  = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_xfer = in_valid && s1_free;

  always_comb begin
    s1_v_nxt = s1_free ? in_valid : s1_v_r;
    s2_v_nxt = s2_free ? s1_v_r : s2_v_r;
    s3_v_nxt = s3_free ? s2_v_r : s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      s2_r <= mid;
    end
    if (s2_adv) begin
      s3_r.duty_tenths <= s2_r.duty_tenths;
      s3_r.pwm_compare <= pwm_compare;
      s3_r.pump_on     <= s2_r.pump_on;
      s3_r.status      <= s2_r.status;
    end
  end

  assign in_stall  = !s1_free;
  assign out_valid = s3_v_r;
  assign out_data  = s3_r;

  `PPDC_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_v_r && !s1_adv, s1_v_r)
  `PPDC_ASSERT_IMPLY(a_stop_zero_duty, clk, rst_n, s2_v_r && (s2_r.status != ST_NORMAL),
                     s2_r.duty_tenths == '0)
  `PPDC_ASSERT_IMPLY(a_zero_duty_full_cmp, clk, rst_n,
                     s3_v_r && (s3_r.duty_tenths == '0), s3_r.pwm_compare == PwmAtZero)

endmodule

/* dv/pump_proportional_duty_ctrl_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_proportional_duty_ctrl_test
// Self-checking bench for the pump duty controller. A queue of control
// updates feeds a valid/stall driver, and an in-bench duty predictor turns
// every input transfer into the expected result. A monitor compares each
// result transfer field by field. Register settings change between phases
// while the pipeline is empty, and both sides stall at random.
// ----------------------------------------------------------------------------
module pump_proportional_duty_ctrl_test;
  import ppdc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PWM_MAX     = (1 << PWM_BITS_DEF) - 1;

  // Register setting styles
  localparam int SET_TYPICAL    = 0;
  localparam int SET_LOW        = 1;
  localparam int SET_HIGH       = 2;
  localparam int SET_WILD       = 3;
  localparam int SET_FLOOR_OVER = 4;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  ppdc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ppdc_out_t             out_data;

  pump_proportional_duty_ctrl i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Register copies used by the predictor
  int          reg_target  = TARGET_PRESSURE_RST;
  int          reg_gain    = PROP_GAIN_RST;
  int          reg_floor   = DUTY_FLOOR_RST;
  int          reg_ceil    = DUTY_CEILING_RST;
  int          reg_slew    = SLEW_STEP_RST;
  int          reg_overvac = OVERVAC_LIMIT_RST;
  logic [31:0] reg_leak    = LEAK_TIMEOUT_RST;

  // Controller state as the predictor sees it
  int          duty_now  = 0;
  bit          reached   = 1'b0;
  bit          timer_on  = 1'b0;
  logic [31:0] timer_t0  = '0;

  ppdc_in_t  update_q[$];
  ppdc_out_t duty_expect_q[$];

  int          items_queued  = 0;
  int          items_sent    = 0;
  int          results_got   = 0;
  int          errors        = 0;
  int          overvac_stops = 0;
  int          leak_stops    = 0;
  int          pump_on_seen  = 0;
  int          held_cycles   = 0;
  int          settings_used = 1;
  int          quiet_cycles  = 0;
  int          tx_gap        = 0;
  int          rx_gap        = 0;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  bit          calm          = 1'b0;
  logic [31:0] clock_ms      = '0;

  function automatic void halt_duty();
    duty_now = 0;
    reached  = 1'b0;
    timer_on = 1'b0;
  endfunction

  // One control update: advances the predictor state and returns the result.
  function automatic ppdc_out_t predict_duty(input ppdc_in_t u);
    ppdc_out_t   r;
    int          p;
    int          err;
    int          want;
    int          nxt;
    int          inv;
    logic [31:0] elapsed;
    logic [1:0]  st;
    st = ST_NORMAL;
    p  = int'($signed(u.pressure));
    if (!u.running) begin
      duty_now = 0;
      timer_on = 1'b0;
    end else if (p < reg_overvac) begin
      halt_duty();
      st = ST_OVERVAC;
    end else begin
      if (!timer_on) begin
        timer_on = 1'b1;
        timer_t0 = u.now_ms;
      end
      err = p - reg_target;
      if (err > 0) begin
        want = (reg_gain * err) >>> 8;
        if (want > reg_ceil) want = reg_ceil;
        if (want < reg_floor) want = reg_floor;
      end else begin
        want = reg_floor;
      end
      if (want - duty_now > reg_slew) nxt = duty_now + reg_slew;
      else if (want - duty_now < -reg_slew) nxt = duty_now - reg_slew;
      else nxt = want;
      if (nxt < 0) nxt = 0;
      if (nxt > reg_ceil) nxt = reg_ceil;
      duty_now = nxt;
      // Reaching the target is recorded before the leak test looks at it.
      if (p <= reg_target) reached = 1'b1;
      elapsed = u.now_ms - timer_t0;
      if (!reached && elapsed > reg_leak) begin
        halt_duty();
        st = ST_LEAK;
      end
    end
    inv = (duty_now >= 1000) ? 0 : 1000 - duty_now;
    r.duty_tenths = 10'(duty_now);
    r.pwm_compare = 10'((inv * PWM_MAX) / 1000);
    r.pump_on     = (duty_now >= reg_floor);
    r.status      = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH at result %0d: %s got %0d, expected %0d", results_got, what,
             got_v, want_v);
    errors++;
  endtask

  // Input side: drives queued updates and predicts each accepted transfer.
  always @(posedge clk) begin : tx_side
    ppdc_out_t due;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due = predict_duty(in_data);
        duty_expect_q.push_back(due);
        items_sent++;
        if (due.status == ST_OVERVAC) overvac_stops++;
        if (due.status == ST_LEAK) leak_stops++;
      end
      if (in_valid && in_stall) held_cycles++;
      if (!in_valid || !in_stall) begin
        // Keep offering while the receiver holds off, so the pipeline fills.
        if (hold_left > 0) tx_gap = 0;
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (!calm && hold_left == 0 && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else if (update_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= update_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall, including one long hold-off in the middle of a phase.
  always @(posedge clk) begin : rx_side
    bit nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && update_q.size() > 40 && items_sent >= 60) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nxt = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(0, 15);
        nxt = 1'b1;
      end else begin
        nxt = 1'b0;
      end
      out_stall <= nxt;
    end
  end

  always @(posedge clk) begin : rx_check
    ppdc_out_t due;
    if (rst_n && out_valid && !out_stall) begin
      results_got++;
      if (out_data.pump_on) pump_on_seen++;
      if (duty_expect_q.size() == 0) begin
        report_mismatch("result with no update pending, duty", out_data.duty_tenths, 0);
      end else begin
        due = duty_expect_q.pop_front();
        if (out_data.duty_tenths !== due.duty_tenths)
          report_mismatch("duty_tenths", out_data.duty_tenths, due.duty_tenths);
        if (out_data.pwm_compare !== due.pwm_compare)
          report_mismatch("pwm_compare", out_data.pwm_compare, due.pwm_compare);
        if (out_data.pump_on !== due.pump_on)
          report_mismatch("pump_on", out_data.pump_on, due.pump_on);
        if (out_data.status !== due.status)
          report_mismatch("status", out_data.status, due.status);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, duty_expect_q.size());
        $display("** pump_proportional_duty_ctrl: FAILED **");
        $finish;
      end
    end
  end

  task automatic add_update(input bit run, input int p, input logic [31:0] t);
    ppdc_in_t u;
    u.running  = run;
    u.pressure = 16'(p);
    u.now_ms   = t;
    update_q.push_back(u);
    items_queued++;
  endtask

  // Pressure sample biased toward the interesting bands of the current setting.
  function automatic int pick_pressure(input int above_pct);
    int r;
    int p;
    int span;
    r    = $urandom_range(0, 99);
    span = reg_target - reg_overvac;
    if (r < above_pct) begin
      p = reg_target + int'($urandom_range(1, 600));
    end else if (r < above_pct + 10) begin
      p = (span > 0) ? reg_overvac + int'($urandom_range(0, span)) : reg_target;
    end else if (r < above_pct + 16) begin
      case ($urandom_range(0, 2))
        0:       p = reg_target;
        1:       p = reg_overvac;
        default: p = reg_overvac - 1;
      endcase
    end else if (r < above_pct + 22) begin
      p = reg_overvac - int'($urandom_range(1, 500));
    end else begin
      p = int'($signed(16'($urandom)));
    end
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p;
  endfunction

  task automatic queue_updates(input int n, input int above_pct, input int step_max);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, step_max);
      add_update($urandom_range(0, 99) >= 8, pick_pressure(above_pct), clock_ms);
    end
  endtask

  // Called only with the pipeline empty, right after wait_idle returns.
  task automatic load_settings(input int style, input bit short_leak);
    logic [31:0] v [0:6];
    int          tgt;
    int          fl;
    tgt = -int'($urandom_range(200, 3000));
    fl  = $urandom_range(0, 500);
    v[CFG_TARGET_PRESSURE] = 32'(tgt);
    v[CFG_PROP_GAIN]       = $urandom_range(64, 2048);
    v[CFG_DUTY_FLOOR]      = 32'(fl);
    v[CFG_DUTY_CEILING]    = $urandom_range(fl, 1000);
    v[CFG_SLEW_STEP]       = $urandom_range(1, 200);
    v[CFG_OVERVAC_LIMIT]   = 32'(tgt - int'($urandom_range(100, 3000)));
    v[CFG_LEAK_TIMEOUT]    = short_leak ? $urandom_range(0, 200) : $urandom_range(500, 100000);
    case (style)
      SET_LOW: begin
        v[CFG_TARGET_PRESSURE] = 32'(-5000);
        v[CFG_PROP_GAIN]       = 0;
        v[CFG_DUTY_FLOOR]      = 0;
        v[CFG_DUTY_CEILING]    = 0;
        v[CFG_SLEW_STEP]       = 0;
        v[CFG_OVERVAC_LIMIT]   = 32'(-10000);
        v[CFG_LEAK_TIMEOUT]    = 0;
      end
      SET_HIGH: begin
        // Ceiling at the top of its field, above full scale.
        v[CFG_TARGET_PRESSURE] = 0;
        v[CFG_PROP_GAIN]       = 4095;
        v[CFG_DUTY_FLOOR]      = 1000;
        v[CFG_DUTY_CEILING]    = 1023;
        v[CFG_SLEW_STEP]       = 1000;
        v[CFG_OVERVAC_LIMIT]   = 0;
        v[CFG_LEAK_TIMEOUT]    = 32'hFFFF_FFFF;
      end
      SET_WILD: begin
        for (int i = 0; i < 7; i++) v[i] = $urandom;
      end
      SET_FLOOR_OVER: begin
        fl = $urandom_range(501, 1000);
        v[CFG_DUTY_FLOOR]   = 32'(fl);
        v[CFG_DUTY_CEILING] = $urandom_range(0, fl - 1);
      end
      default: ;
    endcase
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_target  = int'($signed(v[CFG_TARGET_PRESSURE][13:0]));
    reg_gain    = int'(v[CFG_PROP_GAIN][11:0]);
    reg_floor   = int'(v[CFG_DUTY_FLOOR][9:0]);
    reg_ceil    = int'(v[CFG_DUTY_CEILING][9:0]);
    reg_slew    = int'(v[CFG_SLEW_STEP][9:0]);
    reg_overvac = int'($signed(v[CFG_OVERVAC_LIMIT][14:0]));
    reg_leak    = v[CFG_LEAK_TIMEOUT];
    settings_used++;
  endtask

  // Counters may be read before the latest edge's updates, which only delays the return here.
  task automatic wait_idle();
    while (items_sent != items_queued || results_got != items_sent) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed updates at the reset settings.
    add_update(1'b0, -32768, 32'h0000_0000);
    add_update(1'b0, 32767, 32'hFFFF_FFFF);
    add_update(1'b1, 32767, 32'd0);
    add_update(1'b1, 32767, 32'd10);
    add_update(1'b1, -999, 32'd20);
    add_update(1'b1, -1000, 32'd30);
    add_update(1'b1, -2000, 32'd40);
    add_update(1'b1, -2001, 32'd50);
    add_update(1'b1, -32768, 32'd60);
    // Leak timer: equal to the timeout holds, one past it stops.
    add_update(1'b1, 0, 32'd100);
    add_update(1'b1, 0, 32'd60100);
    add_update(1'b1, 0, 32'd60101);
    add_update(1'b0, 0, 32'd60102);
    // Elapsed time across the 32-bit wrap.
    add_update(1'b1, 0, 32'hFFFF_FFF0);
    add_update(1'b1, 0, 32'h0000_0010);
    add_update(1'b1, 0, 32'h0000_EA51);
    add_update(1'b1, -1000, 32'd70000);
    add_update(1'b1, 32767, 32'd300000);
    add_update(1'b1, 32767, 32'd300010);
    add_update(1'b1, 21845, 32'hAAAA_AAAA);
    add_update(1'b1, -21846, 32'h5555_5555);
    add_update(1'b0, 32767, 32'hFFFF_FFFF);
    wait_idle();

    load_settings(SET_TYPICAL, 1'b0);
    clock_ms = $urandom;
    queue_updates(120, 50, 50);
    wait_idle();

    load_settings(SET_LOW, 1'b0);
    queue_updates(60, 50, 20);
    wait_idle();

    load_settings(SET_HIGH, 1'b0);
    clock_ms = 32'hFFFF_F000;
    queue_updates(80, 60, 1000);
    wait_idle();

    load_settings(SET_TYPICAL, 1'b1);
    queue_updates(100, 78, 30);
    wait_idle();

    load_settings(SET_WILD, 1'b0);
    clock_ms = $urandom;
    queue_updates(80, 40, 100000);
    wait_idle();

    load_settings(SET_FLOOR_OVER, 1'b0);
    queue_updates(80, 55, 50);
    wait_idle();

    calm = 1'b1;
    load_settings(SET_TYPICAL, 1'b0);
    queue_updates(120, 60, 20);
    wait_idle();
    calm = 1'b0;

    load_settings(SET_WILD, 1'b0);
    queue_updates(80, 40, 2000);
    wait_idle();

    load_settings(SET_TYPICAL, 1'b1);
    queue_updates(100, 78, 40);
    wait_idle();

    // Closing stretch runs without any idling on either side.
    calm = 1'b1;
    load_settings(SET_TYPICAL, 1'b0);
    queue_updates(100, 55, 30);
    wait_idle();

    repeat (8) @(posedge clk);
    $display("Ran %0d updates under %0d register settings: %0d over-vacuum and %0d leak stops.",
             items_sent, settings_used, overvac_stops, leak_stops);
    $display("Pump on in %0d results; the block held off the input for %0d cycles.",
             pump_on_seen, held_cycles);
    if (errors == 0) begin
      $display("** pump_proportional_duty_ctrl: PASSED **");
    end else begin
      $display("** pump_proportional_duty_ctrl: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ppdc_pkg.sv
hw/rtl/ppdc_cfg_regs.sv
hw/rtl/ppdc_duty_core.sv
hw/rtl/ppdc_pwm_scale.sv
hw/rtl/pump_proportional_duty_ctrl.sv
dv/pump_proportional_duty_ctrl_test.sv
